@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SBH_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SBH_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/sbh_pkg.sv @@
// ----------------------------------------------------------------------------
// sbh_pkg
// Types, constants and round functions of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sbh_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } sbh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        too_long;
  } sbh_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } sbh_state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic       push;       // shift one byte into the block window
    logic [7:0] push_byte;
    logic       load;       // working vars <= chain
    logic       step;       // one compression round
    logic [5:0] rnd;
    logic       fold;       // chain += working vars (last round)
    logic       reinit;     // chain <= initial value
  } sbh_ctl_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

@@ hdl/sbh_msg_sched.sv @@
// ----------------------------------------------------------------------------
// sbh_msg_sched
// 16-word block window: collects bytes, then expands the message schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module sbh_msg_sched (
  input  wire logic             clk,
  input  wire sbh_pkg::sbh_ctl_t ctl,
  output logic [31:0]           wt
);
  import sbh_pkg::*;

  logic [31:0] win [16];
  logic [31:0] w_new;

  // W[t] = W[t-16] + s0(W[t-15]) + W[t-7] + s1(W[t-2])
  assign w_new = win[0] + ssig0(win[1]) + win[9] + ssig1(win[14]);
  assign wt    = win[0];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], ctl.push_byte};
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sbh_round_core.sv @@
// ----------------------------------------------------------------------------
// sbh_round_core
// Shared compression round unit with working variables and chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sbh_round_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sbh_pkg::sbh_ctl_t ctl,
  input  wire logic [31:0]       wt,
  output logic [31:0]            chain [8]
);
  import sbh_pkg::*;

  logic [31:0] v      [8];
  logic [31:0] v_next [8];
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[ctl.rnd] + wt;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v <= chain;
    end else if (ctl.step) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reinit) begin
      chain <= IV_TAB;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + v_next[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/sbh_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbh_ctrl
// Sequencer: byte intake, padding, round count, length count, digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sbh_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire sbh_pkg::sbh_in_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output logic [2:0]            word_index,
  output logic                  too_long,
  output sbh_pkg::sbh_ctl_t     ctl
);
  import sbh_pkg::*;

  sbh_state_t  state, state_next;
  sbh_state_t  ret_state;
  logic [5:0]  fill;
  logic [60:0] count;
  logic        overflow;
  logic        pad_first;
  logic        len_phase;
  logic [5:0]  rnd;
  logic [2:0]  widx;

  logic        is_len;
  logic        absorb_acc;
  logic        finish_acc;
  logic        wrap;
  logic [63:0] len_bits;
  logic [2:0]  len_sel;

  assign len_bits   = {count, 3'b000};
  assign len_sel    = 3'd7 - fill[2:0];
  assign is_len     = !pad_first && (len_phase || fill == LEN_START);
  assign absorb_acc = (state == ST_IDLE) && req_valid && (req.op == OP_ABSORB);
  assign finish_acc = (state == ST_IDLE) && req_valid && (req.op == OP_FINISH);
  assign wrap       = ctl.push && (fill == FILL_LAST);

  // outputs
  always_comb begin
    req_ready     = 1'b0;
    rsp_valid     = 1'b0;
    ctl.push      = 1'b0;
    ctl.push_byte = req.data_byte;
    ctl.step      = 1'b0;
    ctl.rnd       = rnd;
    ctl.fold      = 1'b0;
    ctl.reinit    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        ctl.push  = absorb_acc;
      end
      ST_PAD: begin
        ctl.push = 1'b1;
        if (pad_first) begin
          ctl.push_byte = PAD_BYTE;
        end else if (is_len) begin
          ctl.push_byte = len_bits[{len_sel, 3'b000} +: 8];
        end else begin
          ctl.push_byte = 8'h00;
        end
      end
      ST_COMP: begin
        ctl.step = 1'b1;
        ctl.fold = (rnd == RND_LAST);
      end
      ST_OUT: begin
        rsp_valid  = 1'b1;
        ctl.reinit = rsp_ready && (widx == WORD_LAST);
      end
      default: begin
      end
    endcase
    ctl.load = ctl.push && (fill == FILL_LAST);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (finish_acc) begin
          state_next = ST_PAD;
        end else if (wrap) begin
          state_next = ST_COMP;
        end
      end
      ST_PAD: begin
        if (wrap) begin
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd == RND_LAST) begin
          state_next = ret_state;
        end
      end
      ST_OUT: begin
        if (rsp_ready && (widx == WORD_LAST)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      fill      <= '0;
      count     <= '0;
      overflow  <= 1'b0;
      pad_first <= 1'b0;
      len_phase <= 1'b0;
      rnd       <= '0;
      widx      <= '0;
    end else begin
      state <= state_next;
      if (ctl.push) begin
        fill <= fill + 6'd1;
      end
      if (wrap) begin
        if (state == ST_PAD && is_len) begin
          ret_state <= ST_OUT;
        end else begin
          ret_state <= state;
        end
      end
      // length saturates at its all-ones value
      if (absorb_acc) begin
        if (&count) begin
          overflow <= 1'b1;
        end else begin
          count <= count + 61'd1;
        end
      end
      if (finish_acc) begin
        pad_first <= 1'b1;
      end else if (state == ST_PAD) begin
        pad_first <= 1'b0;
      end
      if (state == ST_PAD && is_len) begin
        len_phase <= 1'b1;
      end
      if (ctl.step) begin
        rnd <= rnd + 6'd1;
      end
      if (rsp_valid && rsp_ready) begin
        widx <= widx + 3'd1;
      end
      if (ctl.reinit) begin
        count     <= '0;
        overflow  <= 1'b0;
        len_phase <= 1'b0;
      end
    end
  end

  assign word_index = widx;
  assign too_long   = overflow;

endmodule

`default_nettype wire

@@ hdl/sha256_byte_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream: absorb bytes, finish to pad and emit the digest.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  req     | in  | req_valid / req_ready  | op, data_byte
//  rsp     | out | rsp_valid / rsp_ready  | digest_word, word_index, last, too_long
//
//  An absorb item that fills the 64-byte block starts its compression: one round
//  per cycle on the shared round unit, with no new item taken until it is done.
//  A finish item pushes 9 to 72 pad bytes at one a cycle, pausing to compress
//  each block it fills, then offers eight digest items, one per cycle when taken.
//  Reset (rst, synchronous) loads the initial hash and clears all counters.
//  req_ready is high only while idle; rsp stalls hold the chaining words.
//
`default_nettype none
`include "assert_macros.svh"

module sha256_byte_stream_hasher_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire sbh_pkg::sbh_in_t  req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output sbh_pkg::sbh_out_t      rsp
);
  import sbh_pkg::*;

  sbh_ctl_t    ctl;
  logic [31:0] wt;
  logic [31:0] chain [8];
  logic [2:0]  word_index;
  logic        too_long;

  // sequencer
  sbh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .word_index (word_index),
    .too_long   (too_long),
    .ctl        (ctl)
  );

  // block window doubles as the schedule shift line
  sbh_msg_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .wt  (wt)
  );

  // one round per cycle, fold into chain on the last round
  sbh_round_core u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .wt    (wt),
    .chain (chain)
  );

  // digest words come straight from the chaining registers
  always_comb begin
    rsp.digest_word = chain[word_index];
    rsp.word_index  = word_index;
    rsp.last        = (word_index == WORD_LAST);
    rsp.too_long    = too_long;
  end

  `SBH_ASSERT_IMP(a_out_excl_in, rsp_valid, !req_ready)
  `SBH_ASSERT_NXT(a_last_to_idle, rsp_valid && rsp_ready && rsp.last, req_ready)
  `SBH_ASSERT_NXT(a_load_then_round, ctl.load, ctl.step && !req_ready)
  `SBH_ASSERT_NXT(a_words_continue, rsp_valid && rsp_ready && !rsp.last, rsp_valid)

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams messages into the SHA-256 byte stream hasher and checks every
// digest word against an in-bench hash model, with random idling on both sides.
// ----------------------------------------------------------------------------

module testbench;

  import sbh_pkg::*;

  localparam int QUIET_LIMIT = 5000;  // cycles with no item moved on either side
  localparam int END_SETTLE  = 300;   // margin for the longest finish, with its padding work

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  sbh_in_t  req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  sbh_out_t rsp;

  sha256_byte_stream_hasher_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Hash model: chaining words, partial block, byte count, overflow flag
  // --------------------------------------------------------------------------
  logic [31:0] round_const [64];
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [60:0] msg_bytes;
  logic [5:0]  blk_fill;
  logic        len_overflow;

  sbh_out_t pending_digest_words [$];  // digest words still owed by the block

  int  items_accepted    = 0;
  int  finishes_accepted = 0;
  int  error_count       = 0;
  int  quiet_cycles      = 0;
  bit  idle_on           = 1'b1;  // random idling on both sides
  int  rsp_hold          = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void hash_init();
    chain[0] = 32'h6a09e667;
    chain[1] = 32'hbb67ae85;
    chain[2] = 32'h3c6ef372;
    chain[3] = 32'ha54ff53a;
    chain[4] = 32'h510e527f;
    chain[5] = 32'h9b05688c;
    chain[6] = 32'h1f83d9ab;
    chain[7] = 32'h5be0cd19;
    msg_bytes    = '0;
    blk_fill     = '0;
    len_overflow = 1'b0;
  endfunction

  // one 64-round compression of the full block into the chaining words
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++)
      v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
            + round_const[i] + w[i];
      t2  = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain[i] = chain[i] + v[i];
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    blk[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0)
      compress_block();
  endfunction

  function automatic void hash_absorb(input logic [7:0] b);
    // the count saturates at 2^61-1 and flags the message as too long
    if (&msg_bytes)
      len_overflow = 1'b1;
    else
      msg_bytes = msg_bytes + 61'd1;
    push_byte(b);
  endfunction

  // pad, run the last block(s), queue the eight digest words, start over
  function automatic void hash_finish();
    logic [63:0] bit_len;
    sbh_out_t    w;
    bit_len = {msg_bytes, 3'b000};
    push_byte(PAD_BYTE);
    while (blk_fill != LEN_START)
      push_byte(8'h00);
    for (int i = 0; i < 8; i++)
      push_byte(bit_len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      w.digest_word = chain[i];
      w.word_index  = 3'(i);
      w.last        = (3'(i) == WORD_LAST);
      w.too_long    = len_overflow;
      pending_digest_words = {pending_digest_words, w};
    end
    hash_init();
  endfunction

  // --------------------------------------------------------------------------
  // Request side: every accepted item advances the hash model
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      items_accepted++;
      if (req.op == OP_ABSORB) begin
        hash_absorb(req.data_byte);
      end else begin
        finishes_accepted++;
        hash_finish();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: compare each digest word with the oldest one owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sbh_out_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_digest_words.size() == 0) begin
        $error("unexpected digest word: digest_word %h word_index %0d last %0b too_long %0b",
               rsp.digest_word, rsp.word_index, rsp.last, rsp.too_long);
        error_count++;
      end else begin
        want = pending_digest_words.pop_front();
        if (rsp.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, actual %h", want.digest_word, rsp.digest_word);
          error_count++;
        end
        if (rsp.word_index !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index, rsp.word_index);
          error_count++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, rsp.last);
          error_count++;
        end
        if (rsp.too_long !== want.too_long) begin
          $error("too_long: expected %0b, actual %0b", want.too_long, rsp.too_long);
          error_count++;
        end
      end
    end
  end

  // receiver stalls: random bursts with ready low
  always @(negedge clk) begin
    if (rsp_hold == 0 && idle_on && $urandom_range(0, 7) == 0)
      rsp_hold = $urandom_range(1, 13);
    if (rsp_hold > 0) begin
      rsp_ready <= 1'b0;
      rsp_hold--;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // watchdog on cycles where nothing moves on either channel
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Present one item; return at the edge where it is taken. Valid stays high
  // afterwards so the next call can follow back to back.
  task automatic send_item(input logic op, input logic [7:0] b);
    sbh_in_t it;
    it.op        = op;
    it.data_byte = b;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    // data byte on a finish is don't-care; keep it random
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_digests_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_digest_words.size() != 0)
      @(posedge clk);
  endtask

  // empty message, twice in a row: also checks the return to the initial value
  task automatic test_empty_message();
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'hff);
  endtask

  // extreme byte values in one short message
  task automatic test_extreme_bytes();
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_FINISH, 8'h5a);
  endtask

  // "abc": the textbook vector
  task automatic test_known_vector();
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h00);
  endtask

  // sender holds off until the block has delivered every digest word
  task automatic test_drain_pause();
    send_message($urandom_range(1, 10));
    wait_digests_drained();
    send_message($urandom_range(1, 10));
    wait_digests_drained();
  endtask

  // Random messages: a third land around the padding edges (55..65 and
  // 119..129 bytes: one vs. two pad blocks, exact block fills), the rest short.
  task automatic test_random_messages();
    int len;
    int first_item;
    int first_finish;
    first_item   = items_accepted;
    first_finish = finishes_accepted;
    while (items_accepted - first_item < 235 || finishes_accepted - first_finish < 6) begin
      if ($urandom_range(0, 2) == 0)
        len = 64 * $urandom_range(0, 1) + 55 + $urandom_range(0, 10);
      else
        len = $urandom_range(0, 12);
      send_message(len);
      if ($urandom_range(0, 7) == 0)
        wait_digests_drained();
    end
  endtask

  // no idling at all: full-block message and short ones back to back
  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_message(64);
    send_message(0);
    send_message($urandom_range(1, 8));
  endtask

  initial begin
    round_const = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    hash_init();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The 2^61-1 byte length saturation is out of reach in simulation; the
    // model still carries it, so too_long is checked as zero throughout.
    test_empty_message();
    test_extreme_bytes();
    test_known_vector();
    test_drain_pause();
    test_random_messages();
    test_back_to_back();

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_digest_words.size() != 0)
      @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
